/* rtl/lls_pkg.sv */
// Shared constants and types of the light level hysteresis scaler.
package lls_pkg;

  localparam int LEVEL_BITS = 8;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 8'd255;
  localparam logic [LEVEL_BITS-1:0] LEVEL_EQUAL = 8'd50;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MIN = 8'd0;

  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_INVERT_SAMPLE = 3'd0,
    CFG_AUTO_SCALE    = 3'd1,
    CFG_HYSTERESIS    = 3'd2,
    CFG_FIXED_LOW     = 3'd3,
    CFG_FIXED_HIGH    = 3'd4,
    CFG_CLAMP_LOW     = 3'd5,
    CFG_CLAMP_HIGH    = 3'd6
  } cfg_index_t;

endpackage

/* rtl/lls_div.sv */
// Bit-serial restoring divider producing an 8-bit quotient, one bit per cycle.
module lls_div #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [SAMPLE_BITS-1:0]             num_high,
  input  logic [lls_pkg::LEVEL_BITS-1:0]     num_low,
  input  logic [SAMPLE_BITS-1:0]             den,
  output logic                               done,
  output logic [lls_pkg::LEVEL_BITS-1:0]     quot
);
  import lls_pkg::*;

  localparam int CNT_W = $clog2(LEVEL_BITS);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [SAMPLE_BITS-1:0] rem;
  logic [SAMPLE_BITS-1:0] den_r;
  logic [LEVEL_BITS-1:0] low_bits;
  logic [SAMPLE_BITS:0]  trial;
  logic [SAMPLE_BITS:0]  diff;
  logic                  ge;
  logic [SAMPLE_BITS-1:0] rem_next;

  // The top part of the numerator is always below the divisor, since the quotient fits 8 bits.
  assign trial    = {rem, low_bits[LEVEL_BITS-1]};
  assign ge       = trial >= {1'b0, den_r};
  assign diff     = trial - {1'b0, den_r};
  assign rem_next = ge ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(LEVEL_BITS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= num_high;
      low_bits <= num_low;
      den_r    <= den;
    end else if (busy) begin
      rem      <= rem_next;
      low_bits <= {low_bits[LEVEL_BITS-2:0], 1'b0};
      quot     <= {quot[LEVEL_BITS-2:0], ge};
    end
  end

endmodule

/* rtl/light_level_hysteresis_scaler_top.sv */
// Top level of the light level hysteresis scaler: acceptance test, range tracking and output.
// A rejected sample, or an accepted one whose range limits are equal or reversed, passes from the
// evaluation state straight to the output state; the next sample is taken once the result is out.
// A sample that needs the linear map passes through the division state in between, where the
// 8 steps of the bit-serial divider run before the output state and before the next sample.
// Synchronous reset restores the register defaults, the tracking state and a held level of 0.
module light_level_hysteresis_scaler_top #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [lls_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [SAMPLE_BITS-1:0]              cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [SAMPLE_BITS-1:0]              sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lls_pkg::LEVEL_BITS-1:0]      level,
  output logic                                accepted
);
  import lls_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_ONE = SAMPLE_BITS'(1);

  state_t state;
  state_t state_next;

  logic                   invert_sample;
  logic                   auto_scale;
  logic [SAMPLE_BITS-1:0] hysteresis;
  logic [SAMPLE_BITS-1:0] fixed_low;
  logic [SAMPLE_BITS-1:0] fixed_high;
  logic [LEVEL_BITS-1:0]  clamp_low;
  logic [LEVEL_BITS-1:0]  clamp_high;

  logic [SAMPLE_BITS-1:0] last_accepted;
  logic [SAMPLE_BITS-1:0] seen_min;
  logic [SAMPLE_BITS-1:0] seen_max;

  logic [SAMPLE_BITS-1:0] held_sample;
  logic [LEVEL_BITS-1:0]  pre_level;
  logic                   take_r;

  logic [SAMPLE_BITS-1:0]   raw;
  logic signed [SAMPLE_BITS:0] delta;
  logic signed [SAMPLE_BITS:0] neg_delta;
  logic signed [SAMPLE_BITS:0] hyst_ext;
  logic                     take;
  logic [SAMPLE_BITS-1:0]   min_next;
  logic [SAMPLE_BITS-1:0]   max_next;
  logic [SAMPLE_BITS-1:0]   lo;
  logic [SAMPLE_BITS-1:0]   hi;
  logic [SAMPLE_BITS-1:0]   val;
  logic [SAMPLE_BITS-1:0]   span;
  logic [SAMPLE_BITS+LEVEL_BITS-1:0] numer;
  logic [LEVEL_BITS-1:0]    direct_level;
  logic                     use_div;
  logic [LEVEL_BITS-1:0]    clamped;
  logic                     out_free;
  logic                     div_done;
  logic [LEVEL_BITS-1:0]    div_quot;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Acceptance test, range selection and the direct level or divider operands for the latched sample.
  always_comb begin
    raw       = invert_sample ? ~held_sample : held_sample;
    delta     = $signed({1'b0, raw}) - $signed({1'b0, last_accepted});
    neg_delta = -delta;
    hyst_ext  = $signed({1'b0, hysteresis});
    take      = (raw != last_accepted) &&
                ((raw == '0) || (raw == '1) || (delta > hyst_ext) || (neg_delta > hyst_ext));
    min_next  = (raw < seen_min) ? raw : seen_min;
    max_next  = (raw > seen_max) ? raw : seen_max;
    if (auto_scale) begin
      lo  = min_next;
      hi  = max_next;
      val = raw;
    end else begin
      lo = fixed_low;
      hi = fixed_high;
      if (raw < fixed_low) begin
        val = fixed_low;
      end else if (raw > fixed_high) begin
        val = fixed_high;
      end else begin
        val = raw;
      end
    end
    span  = hi - lo;
    numer = {val - lo, {LEVEL_BITS{1'b0}}} - {{LEVEL_BITS{1'b0}}, val - lo};
    if (lo == hi) begin
      direct_level = LEVEL_EQUAL;
      use_div      = 1'b0;
    end else if (lo > hi) begin
      direct_level = (val == lo) ? LEVEL_MIN : LEVEL_MAX;
      use_div      = 1'b0;
    end else begin
      direct_level = LEVEL_MIN;
      use_div      = 1'b1;
    end
  end

  always_comb begin
    if (pre_level < clamp_low) begin
      clamped = clamp_low;
    end else if (pre_level > clamp_high) begin
      clamped = clamp_high;
    end else begin
      clamped = pre_level;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = (take && use_div) ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  lls_div #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    ((state == S_EVAL) && take && use_div),
    .num_high (numer[SAMPLE_BITS+LEVEL_BITS-1:LEVEL_BITS]),
    .num_low  (numer[LEVEL_BITS-1:0]),
    .den      (span),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      invert_sample <= 1'b0;
      auto_scale    <= 1'b1;
      hysteresis    <= SAMPLE_BITS'(40);
      fixed_low     <= '0;
      fixed_high    <= '1;
      clamp_low     <= LEVEL_MIN;
      clamp_high    <= LEVEL_MAX;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_INVERT_SAMPLE: invert_sample <= cfg_data[0];
        CFG_AUTO_SCALE:    auto_scale    <= cfg_data[0];
        CFG_HYSTERESIS:    hysteresis    <= cfg_data;
        CFG_FIXED_LOW:     fixed_low     <= cfg_data;
        CFG_FIXED_HIGH:    fixed_high    <= cfg_data;
        CFG_CLAMP_LOW:     clamp_low     <= cfg_data[LEVEL_BITS-1:0];
        CFG_CLAMP_HIGH:    clamp_high    <= cfg_data[LEVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      last_accepted <= SAMPLE_ONE;
      seen_min      <= '1;
      seen_max      <= '0;
      level         <= LEVEL_MIN;
      accepted      <= 1'b0;
      out_valid     <= 1'b0;
      take_r        <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EVAL) begin
        take_r <= take;
        if (take) begin
          last_accepted <= raw;
          if (auto_scale) begin
            seen_min <= min_next;
            seen_max <= max_next;
          end
        end
      end
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
        accepted  <= take_r;
        if (take_r) begin
          level <= clamped;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && in_valid) begin
      held_sample <= sample;
    end
    if (state == S_EVAL) begin
      pre_level <= direct_level;
    end else if ((state == S_DIV) && div_done) begin
      pre_level <= div_quot;
    end
  end

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the division state");

  a_reject_holds_level: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && out_free && !take_r) |=> (level == $past(level)))
    else $error("rejected sample changed the held level");

  a_level_in_clamp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && accepted && (clamp_low <= clamp_high)) |->
      ((level >= clamp_low) && (level <= clamp_high)))
    else $error("accepted level outside the output limits");

  a_eval_follows_transfer: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> $past(in_valid && !in_stall))
    else $error("evaluation without an input transfer");
`endif

endmodule

/* tb/tb_light_level_hysteresis_scaler_top.sv */
// Self-checking testbench for the light level hysteresis scaler: directed table, then random phases.
`timescale 1ns / 1ps

module tb_light_level_hysteresis_scaler_top;
  import lls_pkg::*;

  localparam int SAMPLE_BITS = 10;
  localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 250;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_INDEX = 3'd7;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic                  accepted;
  } light_result_t;

  typedef enum bit {ROW_SAMPLE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    logic [SAMPLE_BITS-1:0]    data;
    logic [CFG_INDEX_BITS-1:0] idx;
    bit                        typed;
    logic [LEVEL_BITS-1:0]     level;
    logic                      accepted;
  } plan_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [SAMPLE_BITS-1:0]    cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [SAMPLE_BITS-1:0]    sample = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [LEVEL_BITS-1:0]     level;
  logic                      accepted;

  // Predictor copy of the registers and the tracking state.
  logic                   inv_cfg = 1'b0;
  logic                   auto_cfg = 1'b1;
  logic [SAMPLE_BITS-1:0] hyst_cfg = 10'd40;
  logic [SAMPLE_BITS-1:0] fixed_lo_cfg = '0;
  logic [SAMPLE_BITS-1:0] fixed_hi_cfg = 10'd1023;
  logic [LEVEL_BITS-1:0]  clamp_lo_cfg = '0;
  logic [LEVEL_BITS-1:0]  clamp_hi_cfg = 8'd255;
  logic [SAMPLE_BITS-1:0] last_taken = 10'd1;
  logic [SAMPLE_BITS-1:0] seen_lo = 10'd1023;
  logic [SAMPLE_BITS-1:0] seen_hi = '0;
  logic [LEVEL_BITS-1:0]  held_level = '0;

  light_result_t          pending_levels[$];
  plan_row_t              plan[$];
  logic [SAMPLE_BITS-1:0] prev_sample = '0;
  int                     gap_pct = 0;
  int                     stall_pct = 0;
  bit                     hold_req = 1'b0;
  int                     hold_left = 0;
  int                     errors = 0;
  int                     sent = 0;
  int                     results = 0;
  int                     taken_seen = 0;
  int                     cfg_count = 0;
  int                     cycles = 0;

  light_level_hysteresis_scaler_top #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample(sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .level(level),
    .accepted(accepted)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results pending.", cycles,
               pending_levels.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at result %0d, %s: got %0d, expected %0d", results, what, got, want);
    errors++;
  endtask

  task automatic note_config(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [SAMPLE_BITS-1:0] data);
    case (idx)
      CFG_INVERT_SAMPLE: inv_cfg = data[0];
      CFG_AUTO_SCALE:    auto_cfg = data[0];
      CFG_HYSTERESIS:    hyst_cfg = data;
      CFG_FIXED_LOW:     fixed_lo_cfg = data;
      CFG_FIXED_HIGH:    fixed_hi_cfg = data;
      CFG_CLAMP_LOW:     clamp_lo_cfg = data[LEVEL_BITS-1:0];
      CFG_CLAMP_HIGH:    clamp_hi_cfg = data[LEVEL_BITS-1:0];
      default: ;
    endcase
  endtask

  function automatic light_result_t predict_level(input logic [SAMPLE_BITS-1:0] s);
    int raw, last, h, val, lo, hi, lvl, cl, ch;
    logic take;
    light_result_t r;
    raw = s;
    if (inv_cfg) raw = SAMPLE_MAX - raw;
    last = last_taken;
    h = hyst_cfg;
    take = (raw != last) && (raw == 0 || raw == SAMPLE_MAX || raw > last + h || raw < last - h);
    if (take) begin
      val = raw;
      last_taken = raw[SAMPLE_BITS-1:0];
      if (auto_cfg) begin
        lo = seen_lo;
        hi = seen_hi;
        if (val < lo) lo = val;
        if (val > hi) hi = val;
        seen_lo = lo[SAMPLE_BITS-1:0];
        seen_hi = hi[SAMPLE_BITS-1:0];
      end else begin
        lo = fixed_lo_cfg;
        hi = fixed_hi_cfg;
        if (val < lo) val = lo;
        else if (val > hi) val = hi;
      end
      lvl = LEVEL_EQUAL;
      if (lo != hi) begin
        lvl = ((val - lo) * 255) / (hi - lo);
        if (lvl < 0) lvl = 0;
        if (lvl > 255) lvl = 255;
      end
      cl = clamp_lo_cfg;
      ch = clamp_hi_cfg;
      if (lvl < cl) lvl = cl;
      else if (lvl > ch) lvl = ch;
      held_level = lvl[LEVEL_BITS-1:0];
    end
    r.level = held_level;
    r.accepted = take;
    return r;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int r, h, v;
    r = $urandom_range(99);
    h = hyst_cfg;
    if (r < 10) begin
      v = $urandom_range(1) ? SAMPLE_MAX : 0;
    end else if (r < 40) begin
      v = $urandom_range(SAMPLE_MAX);
    end else begin
      if (h > 200) h = 200;
      v = int'(prev_sample) + int'($urandom_range(2 * h + 20)) - (h + 10);
      if (v < 0) v = 0;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer, valid left high.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input bit typed,
                             input logic [LEVEL_BITS-1:0] want_level, input logic want_acc);
    light_result_t r;
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (in_stall);
    r = predict_level(s);
    if (typed) begin
      r.level = want_level;
      r.accepted = want_acc;
    end
    pending_levels.push_back(r);
    prev_sample = s;
    sent++;
    @(negedge clk);
  endtask

  // Register writes only go in once every pending result has come out.
  task automatic cfg_put(input logic [CFG_INDEX_BITS-1:0] idx, input logic [SAMPLE_BITS-1:0] data);
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    note_config(idx, data);
    cfg_count++;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic apply_phase(input int p);
    logic inv, aut;
    int hy, fl, fh, cl, ch;
    logic [SAMPLE_BITS-1:0] d;
    case (p)
      0: begin inv = 0; aut = 1; hy = 40;   fl = 0;    fh = 1023; cl = 0;   ch = 255; end
      1: begin inv = 1; aut = 1; hy = 0;    fl = 0;    fh = 1023; cl = 0;   ch = 255; end
      2: begin inv = 0; aut = 0; hy = 1023; fl = 1023; fh = 0;    cl = 255; ch = 0;   end
      3: begin inv = 1; aut = 0; hy = 5;    fl = 200;  fh = 800;  cl = 20;  ch = 230; end
      default: begin
        inv = 1'($urandom_range(1));
        aut = 1'($urandom_range(1));
        hy = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(60);
        fl = $urandom_range(1023);
        fh = $urandom_range(1023);
        cl = $urandom_range(255);
        ch = $urandom_range(255);
      end
    endcase
    d = SAMPLE_BITS'($urandom_range(1023));
    d[0] = inv;
    cfg_put(CFG_INVERT_SAMPLE, d);
    d = SAMPLE_BITS'($urandom_range(1023));
    d[0] = aut;
    cfg_put(CFG_AUTO_SCALE, d);
    cfg_put(CFG_HYSTERESIS, hy[SAMPLE_BITS-1:0]);
    cfg_put(CFG_FIXED_LOW, fl[SAMPLE_BITS-1:0]);
    cfg_put(CFG_FIXED_HIGH, fh[SAMPLE_BITS-1:0]);
    d = SAMPLE_BITS'($urandom_range(1023));
    d[LEVEL_BITS-1:0] = cl[LEVEL_BITS-1:0];
    cfg_put(CFG_CLAMP_LOW, d);
    d = SAMPLE_BITS'($urandom_range(1023));
    d[LEVEL_BITS-1:0] = ch[LEVEL_BITS-1:0];
    cfg_put(CFG_CLAMP_HIGH, d);
  endtask

  // The receiver may be told to hold off for a long stretch so that the block backs up.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    light_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results++;
      if (pending_levels.size() == 0) begin
        report_mismatch("result with nothing pending, level", level, -1);
      end else begin
        want = pending_levels.pop_front();
        if (level !== want.level) report_mismatch("level", level, want.level);
        if (accepted !== want.accepted) report_mismatch("accepted", accepted, want.accepted);
        if (want.accepted) taken_seen++;
      end
    end
  end

  initial begin
    plan = '{
      '{ROW_SAMPLE, 10'd0,    CFG_INVERT_SAMPLE, 1'b1, 8'd50,  1'b1},
      '{ROW_SAMPLE, 10'd1023, CFG_INVERT_SAMPLE, 1'b1, 8'd255, 1'b1},
      '{ROW_SAMPLE, 10'd1023, CFG_INVERT_SAMPLE, 1'b1, 8'd255, 1'b0},
      '{ROW_SAMPLE, 10'd0,    CFG_INVERT_SAMPLE, 1'b1, 8'd0,   1'b1},
      '{ROW_SAMPLE, 10'd20,   CFG_INVERT_SAMPLE, 1'b1, 8'd0,   1'b0},
      '{ROW_SAMPLE, 10'd41,   CFG_INVERT_SAMPLE, 1'b0, 8'd0,   1'b0},
      '{ROW_SAMPLE, 10'd512,  CFG_INVERT_SAMPLE, 1'b0, 8'd0,   1'b0},
      '{ROW_CFG,    10'd0,    CFG_HYSTERESIS,    1'b0, 8'd0,   1'b0},
      '{ROW_SAMPLE, 10'd513,  CFG_INVERT_SAMPLE, 1'b0, 8'd0,   1'b0},
      '{ROW_SAMPLE, 10'd513,  CFG_INVERT_SAMPLE, 1'b0, 8'd0,   1'b0},
      '{ROW_CFG,    10'h3FF,  CFG_INVERT_SAMPLE, 1'b0, 8'd0,   1'b0},
      '{ROW_SAMPLE, 10'd0,    CFG_INVERT_SAMPLE, 1'b1, 8'd255, 1'b1},
      '{ROW_SAMPLE, 10'd1023, CFG_INVERT_SAMPLE, 1'b1, 8'd0,   1'b1},
      '{ROW_CFG,    10'h3FE,  CFG_AUTO_SCALE,    1'b0, 8'd0,   1'b0},
      '{ROW_CFG,    10'd100,  CFG_FIXED_LOW,     1'b0, 8'd0,   1'b0},
      '{ROW_CFG,    10'd900,  CFG_FIXED_HIGH,    1'b0, 8'd0,   1'b0},
      '{ROW_CFG,    10'h3FE,  CFG_INVERT_SAMPLE, 1'b0, 8'd0,   1'b0},
      '{ROW_SAMPLE, 10'd50,   CFG_INVERT_SAMPLE, 1'b0, 8'd0,   1'b0},
      '{ROW_SAMPLE, 10'd950,  CFG_INVERT_SAMPLE, 1'b0, 8'd0,   1'b0},
      '{ROW_SAMPLE, 10'd500,  CFG_INVERT_SAMPLE, 1'b0, 8'd0,   1'b0},
      '{ROW_CFG,    10'd900,  CFG_FIXED_LOW,     1'b0, 8'd0,   1'b0},
      '{ROW_CFG,    10'd100,  CFG_FIXED_HIGH,    1'b0, 8'd0,   1'b0},
      '{ROW_SAMPLE, 10'd300,  CFG_INVERT_SAMPLE, 1'b1, 8'd0,   1'b1},
      '{ROW_SAMPLE, 10'd950,  CFG_INVERT_SAMPLE, 1'b1, 8'd255, 1'b1},
      '{ROW_CFG,    10'h3C8,  CFG_CLAMP_LOW,     1'b0, 8'd0,   1'b0},
      '{ROW_CFG,    10'd100,  CFG_CLAMP_HIGH,    1'b0, 8'd0,   1'b0},
      '{ROW_SAMPLE, 10'd0,    CFG_INVERT_SAMPLE, 1'b1, 8'd200, 1'b1},
      '{ROW_SAMPLE, 10'd1023, CFG_INVERT_SAMPLE, 1'b1, 8'd100, 1'b1},
      '{ROW_CFG,    10'd500,  CFG_FIXED_LOW,     1'b0, 8'd0,   1'b0},
      '{ROW_CFG,    10'd500,  CFG_FIXED_HIGH,    1'b0, 8'd0,   1'b0},
      '{ROW_SAMPLE, 10'd10,   CFG_INVERT_SAMPLE, 1'b1, 8'd200, 1'b1},
      '{ROW_CFG,    10'd1023, CFG_SPARE_INDEX,   1'b0, 8'd0,   1'b0},
      '{ROW_SAMPLE, 10'd600,  CFG_INVERT_SAMPLE, 1'b0, 8'd0,   1'b0},
      '{ROW_CFG,    10'd0,    CFG_CLAMP_LOW,     1'b0, 8'd0,   1'b0},
      '{ROW_CFG,    10'd255,  CFG_CLAMP_HIGH,    1'b0, 8'd0,   1'b0},
      '{ROW_CFG,    10'd0,    CFG_FIXED_LOW,     1'b0, 8'd0,   1'b0},
      '{ROW_CFG,    10'd1023, CFG_FIXED_HIGH,    1'b0, 8'd0,   1'b0},
      '{ROW_CFG,    10'd1,    CFG_AUTO_SCALE,    1'b0, 8'd0,   1'b0},
      '{ROW_CFG,    10'd40,   CFG_HYSTERESIS,    1'b0, 8'd0,   1'b0},
      '{ROW_SAMPLE, 10'd700,  CFG_INVERT_SAMPLE, 1'b0, 8'd0,   1'b0},
      '{ROW_SAMPLE, 10'd1,    CFG_INVERT_SAMPLE, 1'b0, 8'd0,   1'b0}
    };

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].kind == ROW_CFG) begin
        cfg_put(plan[i].idx, plan[i].data);
      end else begin
        send_sample(plan[i].data, plan[i].typed, plan[i].level, plan[i].accepted);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      apply_phase(p);
      gap_pct = (p % 4 == 1) ? 58 : (p % 4 == 3) ? 16 : 0;
      stall_pct = (p % 4 == 2) ? 58 : (p % 4 == 3) ? 16 : 0;
      if (p == 4) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_sample(pick_sample(), 1'b0, '0, 1'b0);
      end
    end

    in_valid <= 1'b0;
    for (int k = 0; k < 20000 && pending_levels.size() != 0; k++) @(negedge clk);
    repeat (3 * SETTLE_CYCLES) @(negedge clk);
    if (pending_levels.size() != 0) begin
      report_mismatch("results never delivered, count", pending_levels.size(), 0);
    end

    $display("Run covered %0d sample transfers, %0d of them accepted, and %0d register writes,",
             sent, taken_seen, cfg_count);
    $display("across %0d settings with idle, stall and long hold-off patterns; %0d mismatches.",
             PHASES + 1, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
